>>> hw/rtl/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first scheduler.
// Holds the request and result structs, the job table port structs and the sequencer states.
// No dependencies.
package srtf_pkg;

    // Table size and the width of stored arrival and run times.
    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Largest value of the current time and of the turnaround sum.
    localparam logic [31:0] TIME_MAX = '1;

    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [TIME_BITS-1:0] tval_t;
    typedef logic [NUM_SLOTS-1:0] slot_vec_t;

    // One request.
    typedef struct packed {
        logic        opcode;
        logic [3:0]  slot;
        logic [15:0] arrival_time;
        logic [15:0] run_time;
    } req_t;

    // One result.
    typedef struct packed {
        logic [31:0] tick_time;
        logic        idle;
        logic [3:0]  chosen_slot;
        logic        started;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] total_turnaround;
        logic        all_done;
    } rsp_t;

    // Write command into the job table.
    typedef struct packed {
        logic  load;
        logic  serve;
        logic  fin;
        idx_t  addr;
        tval_t arrival;
        tval_t remaining;
    } tbl_wr_t;

    // Per-slot status flags kept by the job table.
    typedef struct packed {
        slot_vec_t valid;
        slot_vec_t done;
        slot_vec_t started;
    } tbl_flags_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_UPDATE,
        ST_REPORT
    } state_t;

endpackage

>>> hw/rtl/srtf_job_table.sv
// Job table: arrival and remaining-time memories with one write port and a registered read.
// Also keeps the valid, done and started flags of every slot.
// Depends on srtf_pkg.
module srtf_job_table (
    input  logic                clk,
    input  logic                rst_n,
    input  srtf_pkg::tbl_wr_t   wr,
    input  srtf_pkg::idx_t      rd_addr,
    output srtf_pkg::tval_t     rd_arrival,
    output srtf_pkg::tval_t     rd_remaining,
    output srtf_pkg::tbl_flags_t flags
);

    srtf_pkg::tval_t arrival_mem   [srtf_pkg::NUM_SLOTS];
    srtf_pkg::tval_t remaining_mem [srtf_pkg::NUM_SLOTS];
    srtf_pkg::tval_t rd_arrival_reg;
    srtf_pkg::tval_t rd_remaining_reg;
    srtf_pkg::tbl_flags_t flags_reg;
    srtf_pkg::tbl_flags_t flags_next;

    // Memory writes: a load sets both words, a served job only its remaining time.
    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            arrival_mem[wr.addr] <= wr.arrival;
        end
        if (wr.load || wr.serve)
        begin
            remaining_mem[wr.addr] <= wr.remaining;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_arrival_reg   <= arrival_mem[rd_addr];
        rd_remaining_reg <= remaining_mem[rd_addr];
    end

    // Flag updates: a load restarts the slot, a served job is marked started and maybe done.
    always_comb
    begin
        flags_next = flags_reg;
        if (wr.load)
        begin
            flags_next.valid[wr.addr]   = 1'b1;
            flags_next.started[wr.addr] = 1'b0;
            flags_next.done[wr.addr]    = (wr.remaining == '0);
        end
        else if (wr.serve)
        begin
            flags_next.started[wr.addr] = 1'b1;
            if (wr.fin)
            begin
                flags_next.done[wr.addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign rd_arrival   = rd_arrival_reg;
    assign rd_remaining = rd_remaining_reg;
    assign flags        = flags_reg;

endmodule

>>> hw/rtl/srtf_ctrl.sv
// Scheduler sequencer: scans the job table one slot per cycle through a shared compare unit,
// then updates the chosen job, the time and the turnaround sum, and registers the result.
// Depends on srtf_pkg.
module srtf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  srtf_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output srtf_pkg::rsp_t       rsp,
    output srtf_pkg::tbl_wr_t    tbl_wr,
    output srtf_pkg::idx_t       tbl_rd_addr,
    input  srtf_pkg::tval_t      tbl_rd_arrival,
    input  srtf_pkg::tval_t      tbl_rd_remaining,
    input  srtf_pkg::tbl_flags_t tbl_flags
);

    localparam srtf_pkg::idx_t LAST_IDX = srtf_pkg::IDX_BITS'(srtf_pkg::NUM_SLOTS - 1);

    srtf_pkg::state_t state_reg, state_next;

    srtf_pkg::idx_t  cnt_reg, cnt_next;
    logic            cmp_vld_reg, cmp_vld_next;
    srtf_pkg::idx_t  cmp_idx_reg, cmp_idx_next;
    logic            found_reg, found_next;
    srtf_pkg::tval_t best_reg, best_next;
    srtf_pkg::idx_t  pick_reg, pick_next;
    logic [31:0]     now_reg, now_next;
    logic [31:0]     served_reg, served_next;
    logic [31:0]     sum_reg, sum_next;
    logic [31:0]     ta_reg, ta_next;
    logic            first_reg, first_next;
    logic            fin_reg, fin_next;
    logic            rsp_valid_reg, rsp_valid_next;
    srtf_pkg::rsp_t  rsp_reg, rsp_next;

    logic            do_accept;
    logic            scan_issue;
    logic            do_update;
    logic            out_load;
    logic            eligible;
    logic            better;
    logic [31:0]     now_inc;
    srtf_pkg::tval_t rem_dec;
    logic [32:0]     sum_ext;
    logic            slot_ok;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                if (req_valid && req.opcode == srtf_pkg::OP_TICK)
                begin
                    state_next = srtf_pkg::ST_SCAN;
                end
            end
            srtf_pkg::ST_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = srtf_pkg::ST_DRAIN;
                end
            end
            srtf_pkg::ST_DRAIN:  state_next = srtf_pkg::ST_FETCH;
            srtf_pkg::ST_FETCH:  state_next = srtf_pkg::ST_UPDATE;
            srtf_pkg::ST_UPDATE: state_next = srtf_pkg::ST_REPORT;
            srtf_pkg::ST_REPORT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = srtf_pkg::ST_IDLE;
                end
            end
            default: state_next = srtf_pkg::ST_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb
    begin
        req_ready  = (state_reg == srtf_pkg::ST_IDLE);
        scan_issue = (state_reg == srtf_pkg::ST_SCAN);
        do_update  = (state_reg == srtf_pkg::ST_UPDATE);
        out_load   = (state_reg == srtf_pkg::ST_REPORT) && (!rsp_valid_reg || rsp_ready);
    end

    assign do_accept = req_valid && req_ready;
    assign slot_ok   = ({28'd0, req.slot} < 32'(srtf_pkg::NUM_SLOTS));

    // Shared compare unit: one slot per cycle, lowest index wins ties.
    assign eligible = cmp_vld_reg && tbl_flags.valid[cmp_idx_reg] && !tbl_flags.done[cmp_idx_reg]
                      && (32'(tbl_rd_arrival) <= now_reg);
    assign better   = !found_reg || (tbl_rd_remaining < best_reg);

    // Update arithmetic.
    assign now_inc = (now_reg == srtf_pkg::TIME_MAX) ? now_reg : now_reg + 32'd1;
    assign rem_dec = tbl_rd_remaining - srtf_pkg::TIME_BITS'(1);
    assign sum_ext = {1'b0, sum_reg} + {1'b0, ta_reg};

    // Table read address: the scan counter while scanning, the chosen slot afterwards.
    assign tbl_rd_addr = scan_issue ? cnt_reg : pick_reg;

    // Table write command from a load request or from serving the chosen job.
    always_comb
    begin
        tbl_wr.load      = do_accept && (req.opcode == srtf_pkg::OP_LOAD) && slot_ok;
        tbl_wr.serve     = do_update && found_reg;
        tbl_wr.fin       = (rem_dec == '0);
        tbl_wr.addr      = tbl_wr.load ? srtf_pkg::IDX_BITS'(req.slot) : pick_reg;
        tbl_wr.arrival   = srtf_pkg::TIME_BITS'(req.arrival_time);
        tbl_wr.remaining = tbl_wr.load ? srtf_pkg::TIME_BITS'(req.run_time) : rem_dec;
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next       = cnt_reg;
        cmp_vld_next   = scan_issue;
        cmp_idx_next   = cnt_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        now_next       = now_reg;
        served_next    = served_reg;
        sum_next       = sum_reg;
        ta_next        = ta_reg;
        first_next     = first_reg;
        fin_next       = fin_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (do_accept)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
            best_next  = '0;
            pick_next  = '0;
        end

        if (scan_issue)
        begin
            cnt_next = cnt_reg + srtf_pkg::IDX_BITS'(1);
        end

        if (eligible && better)
        begin
            found_next = 1'b1;
            best_next  = tbl_rd_remaining;
            pick_next  = cmp_idx_reg;
        end

        if (do_update)
        begin
            served_next = now_reg;
            now_next    = now_inc;
            first_next  = found_reg && !tbl_flags.started[pick_reg];
            fin_next    = found_reg && (rem_dec == '0);
            ta_next     = (found_reg && (rem_dec == '0)) ? now_inc - 32'(tbl_rd_arrival) : 32'd0;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (out_load)
        begin
            if (fin_reg)
            begin
                sum_next = sum_ext[32] ? srtf_pkg::TIME_MAX : sum_ext[31:0];
            end
            rsp_valid_next            = 1'b1;
            rsp_next.tick_time        = served_reg;
            rsp_next.idle             = !found_reg;
            rsp_next.chosen_slot      = found_reg ? 4'(pick_reg) : 4'd0;
            rsp_next.started          = first_reg;
            rsp_next.finished         = fin_reg;
            rsp_next.turnaround       = ta_reg;
            rsp_next.total_turnaround = sum_next;
            rsp_next.all_done         = !(|(tbl_flags.valid & ~tbl_flags.done));
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtf_pkg::ST_IDLE;
            cmp_vld_reg   <= 1'b0;
            now_reg       <= 32'd1;
            sum_reg       <= 32'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            now_reg       <= now_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        served_reg  <= served_next;
        ta_reg      <= ta_next;
        first_reg   <= first_next;
        fin_reg     <= fin_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/srtf_scheduler.sv
// Top level of the shortest-remaining-time-first scheduler: sequencer plus job table.
// A load request is written into the table when taken and gives no result. A tick result is
// registered after one table read per slot in the scan state, then drain, fetch of the chosen
// job, update and report states; the single table read port sets this sequence. The report
// state waits while the last result is not taken; then the next request is taken from idle.
// Reset (rst_n, asynchronous, active low) clears slot flags, sets time to 1 and the sum to 0.
module srtf_scheduler (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  srtf_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output srtf_pkg::rsp_t rsp
);

    srtf_pkg::tbl_wr_t    tbl_wr;
    srtf_pkg::idx_t       tbl_rd_addr;
    srtf_pkg::tval_t      tbl_rd_arrival;
    srtf_pkg::tval_t      tbl_rd_remaining;
    srtf_pkg::tbl_flags_t tbl_flags;

    // Sequencer with the shared compare unit.
    srtf_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .tbl_wr           (tbl_wr),
        .tbl_rd_addr      (tbl_rd_addr),
        .tbl_rd_arrival   (tbl_rd_arrival),
        .tbl_rd_remaining (tbl_rd_remaining),
        .tbl_flags        (tbl_flags)
    );

    // Job table memories and slot flags.
    srtf_job_table u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (tbl_wr),
        .rd_addr      (tbl_rd_addr),
        .rd_arrival   (tbl_rd_arrival),
        .rd_remaining (tbl_rd_remaining),
        .flags        (tbl_flags)
    );

endmodule

>>> hw/rtl/srtf_checker.sv
// Port-level checks for the scheduler, attached to the top level by a bind statement.
// Depends on srtf_pkg and srtf_scheduler.
module srtf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input srtf_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input srtf_pkg::rsp_t rsp
);

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // An idle tick reports no job.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.idle |-> rsp.chosen_slot == 4'd0 && !rsp.started
                                  && !rsp.finished && rsp.turnaround == 32'd0)
        else $error("idle tick reports a job");

    // Turnaround is only reported for a finished job.
    a_ta_finish: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.finished |-> rsp.turnaround == 32'd0)
        else $error("turnaround without finish");

    // A tick occupies the block: no request is taken in the next cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.opcode == srtf_pkg::OP_TICK |=> !req_ready)
        else $error("request taken during a tick");

    // Time starts at one and never wraps to zero.
    a_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.tick_time != 32'd0)
        else $error("tick time is zero");

endmodule

bind srtf_scheduler srtf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for srtf_scheduler: a short table of directed requests, then random
// job batches, all checked against an in-bench model of the scheduling policy.
// Depends on srtf_pkg and srtf_scheduler.
module tb;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1130;

    // One request with an optional hand-written result.
    typedef struct {
        srtf_pkg::req_t rq;
        bit             typed;
        srtf_pkg::rsp_t want;
    } row_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    srtf_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    srtf_pkg::rsp_t rsp;

    srtf_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Job table and clocks of the scheduling model.
    logic [15:0]                    job_arrival [srtf_pkg::NUM_SLOTS];
    logic [15:0]                    job_left    [srtf_pkg::NUM_SLOTS];
    logic [srtf_pkg::NUM_SLOTS-1:0] job_valid;
    logic [srtf_pkg::NUM_SLOTS-1:0] job_done;
    logic [srtf_pkg::NUM_SLOTS-1:0] job_started;
    logic [31:0]                    clock_now;
    logic [31:0]                    ta_total;

    srtf_pkg::rsp_t expected_results [$];
    row_t sent_rows [$];
    row_t dir_rows [$];

    int errors       = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int gen_time     = 1;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Applies one request to the model; returns 1 and the schedule outcome for a tick.
    function automatic bit predict_schedule(input srtf_pkg::req_t rq,
                                            output srtf_pkg::rsp_t res);
        bit          found;
        int          pick;
        logic [15:0] best;
        logic [31:0] served;
        logic [31:0] ta;
        bit          first;
        bit          fin;
        found = 1'b0;
        pick  = 0;
        best  = '0;
        ta    = '0;
        first = 1'b0;
        fin   = 1'b0;
        res   = '0;
        if (rq.opcode == srtf_pkg::OP_LOAD)
        begin
            if (int'(rq.slot) < srtf_pkg::NUM_SLOTS)
            begin
                job_arrival[rq.slot] = rq.arrival_time;
                job_left[rq.slot]    = rq.run_time;
                job_valid[rq.slot]   = 1'b1;
                job_started[rq.slot] = 1'b0;
                job_done[rq.slot]    = (rq.run_time == '0);
            end
            return 1'b0;
        end
        // Least remaining time among ready jobs; the lowest slot wins a tie.
        for (int i = 0; i < srtf_pkg::NUM_SLOTS; i++)
        begin
            if (job_valid[i] && !job_done[i] && {16'd0, job_arrival[i]} <= clock_now)
            begin
                if (!found || job_left[i] < best)
                begin
                    found = 1'b1;
                    best  = job_left[i];
                    pick  = i;
                end
            end
        end
        served = clock_now;
        if (clock_now != srtf_pkg::TIME_MAX)
            clock_now = clock_now + 32'd1;
        if (found)
        begin
            job_left[pick]    = job_left[pick] - 16'd1;
            first             = !job_started[pick];
            job_started[pick] = 1'b1;
            if (job_left[pick] == '0)
            begin
                fin            = 1'b1;
                job_done[pick] = 1'b1;
                ta             = clock_now - {16'd0, job_arrival[pick]};
                if (ta_total > srtf_pkg::TIME_MAX - ta)
                    ta_total = srtf_pkg::TIME_MAX;
                else
                    ta_total = ta_total + ta;
            end
        end
        res.tick_time        = served;
        res.idle             = !found;
        res.chosen_slot      = found ? pick[3:0] : 4'd0;
        res.started          = first;
        res.finished         = fin;
        res.turnaround       = ta;
        res.total_turnaround = ta_total;
        res.all_done         = ((job_valid & ~job_done) == '0);
        return 1'b1;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s got %0h want %0h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result(input srtf_pkg::rsp_t got, input srtf_pkg::rsp_t want);
        check_field("tick_time", got.tick_time, want.tick_time);
        check_field("idle", 32'(got.idle), 32'(want.idle));
        check_field("chosen_slot", 32'(got.chosen_slot), 32'(want.chosen_slot));
        check_field("started", 32'(got.started), 32'(want.started));
        check_field("finished", 32'(got.finished), 32'(want.finished));
        check_field("turnaround", got.turnaround, want.turnaround);
        check_field("total_turnaround", got.total_turnaround, want.total_turnaround);
        check_field("all_done", 32'(got.all_done), 32'(want.all_done));
    endtask

    function automatic srtf_pkg::req_t random_fields(input logic op);
        srtf_pkg::req_t rq;
        rq.opcode       = op;
        rq.slot         = 4'($urandom_range(0, 15));
        rq.arrival_time = 16'($urandom_range(0, 65535));
        rq.run_time     = 16'($urandom_range(0, 65535));
        return rq;
    endfunction

    task automatic add_row(input logic op, input int slot, input int arr, input int run,
                           input bit typed, input srtf_pkg::rsp_t want);
        row_t row;
        row.rq.opcode       = op;
        row.rq.slot         = 4'(slot);
        row.rq.arrival_time = 16'(arr);
        row.rq.run_time     = 16'(run);
        row.typed           = typed;
        row.want            = want;
        dir_rows.push_back(row);
    endtask

    // Offers one request, with a random gap in front, and waits until it is taken.
    task automatic send_item(input srtf_pkg::req_t rq, input bit typed,
                             input srtf_pkg::rsp_t want);
        row_t row;
        int   gap;
        row.rq    = rq;
        row.typed = typed;
        row.want  = want;
        sent_rows.push_back(row);
        if ((items_sent >= 600 && items_sent < 800) || $urandom_range(0, 99) >= 18)
            gap = 0;
        else
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= rq;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        if (rq.opcode == srtf_pkg::OP_TICK)
            gen_time++;
    endtask

    // Every accepted request goes through the model; ticks queue an expected result.
    always @(posedge clk)
    begin : req_monitor
        row_t           row;
        srtf_pkg::rsp_t pred;
        if (rst_n && req_valid && req_ready)
        begin
            row = sent_rows.pop_front();
            if (predict_schedule(req, pred))
                expected_results.push_back(row.typed ? row.want : pred);
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin : rsp_monitor
        srtf_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no tick waiting",
                                          results_seen));
            else
            begin
                want = expected_results.pop_front();
                check_result(rsp, want);
            end
        end
    end

    // Result side: random stalls, one long hold-off, and a stretch with no stalls.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 150)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= (results_seen >= 300 && results_seen < 450) ||
                         ($urandom_range(0, 99) >= 18);
        end
    end

    // Ends the run when nothing has been accepted on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Reset, directed table, random job batches, then drain.
    initial
    begin : stimulus
        srtf_pkg::req_t rq;
        int             burst;
        int             a;
        int             pick;
        job_valid   = '0;
        job_done    = '0;
        job_started = '0;
        clock_now   = 32'd1;
        ta_total    = '0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle tick straight after reset.
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b1,
                '{tick_time: 32'd1, idle: 1'b1, chosen_slot: 4'd0, started: 1'b0,
                  finished: 1'b0, turnaround: 32'd0, total_turnaround: 32'd0,
                  all_done: 1'b1});
        // A zero run time loads as already finished.
        add_row(srtf_pkg::OP_LOAD, 15, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b1,
                '{tick_time: 32'd2, idle: 1'b1, chosen_slot: 4'd0, started: 1'b0,
                  finished: 1'b0, turnaround: 32'd0, total_turnaround: 32'd0,
                  all_done: 1'b1});
        // A one-tick job starts and finishes at once.
        add_row(srtf_pkg::OP_LOAD, 3, 0, 1, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b1,
                '{tick_time: 32'd3, idle: 1'b0, chosen_slot: 4'd3, started: 1'b1,
                  finished: 1'b1, turnaround: 32'd4, total_turnaround: 32'd4,
                  all_done: 1'b1});
        // A job far in the future keeps the table busy while ticks stay idle.
        add_row(srtf_pkg::OP_LOAD, 0, 65535, 65535, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b1,
                '{tick_time: 32'd4, idle: 1'b1, chosen_slot: 4'd0, started: 1'b0,
                  finished: 1'b0, turnaround: 32'd0, total_turnaround: 32'd4,
                  all_done: 1'b0});
        // Equal remaining times: the lower slot runs.
        add_row(srtf_pkg::OP_LOAD, 5, 0, 3, 1'b0, '0);
        add_row(srtf_pkg::OP_LOAD, 6, 0, 3, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        // Reload of a running job restarts it.
        add_row(srtf_pkg::OP_LOAD, 5, 1, 2, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_LOAD, 9, 200, 1, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 15, 65535, 65535, 1'b0, '0);
        // Reload the future job with zero run time.
        add_row(srtf_pkg::OP_LOAD, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(srtf_pkg::OP_TICK, 0, 0, 0, 1'b0, '0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        while (items_sent < dir_rows.size() + RANDOM_ITEMS)
        begin
            burst = $urandom_range(0, 99);
            if (burst < 8)
            begin
                // Clear the whole table, then tick so that all jobs read as done.
                for (int s = 0; s < srtf_pkg::NUM_SLOTS; s++)
                begin
                    rq          = random_fields(srtf_pkg::OP_LOAD);
                    rq.slot     = 4'(s);
                    rq.run_time = '0;
                    send_item(rq, 1'b0, '0);
                end
                repeat (2) send_item(random_fields(srtf_pkg::OP_TICK), 1'b0, '0);
            end
            else if (burst < 15)
            begin
                // Noise: fully random requests.
                repeat ($urandom_range(1, 4))
                    send_item(random_fields(1'($urandom_range(0, 1))), 1'b0, '0);
            end
            else
            begin
                // A batch of jobs near the current time, then a run of ticks.
                repeat ($urandom_range(1, 4))
                begin
                    rq   = random_fields(srtf_pkg::OP_LOAD);
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                    begin
                        a = gen_time + $urandom_range(0, 6) - $urandom_range(0, 10);
                        if (a < 0)
                            a = 0;
                        rq.arrival_time = 16'(a);
                    end
                    else if (pick < 75)
                        rq.arrival_time = '0;
                    else if (pick < 90)
                        rq.arrival_time = 16'(gen_time + $urandom_range(10, 60));
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                        rq.run_time = '0;
                    else if (pick < 92)
                        rq.run_time = 16'($urandom_range(1, 12));
                    send_item(rq, 1'b0, '0);
                end
                repeat ($urandom_range(1, 12))
                    send_item(random_fields(srtf_pkg::OP_TICK), 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        // Wait for the last results, then give the block time to show any extra one.
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
